// File: design/qmn_pkg.sv
// ----------------------------------------------------------------------------
// qmn_pkg: shared types and constants for the normalized quaternion product
// Formats, payload structs and the sideband carried through the root pipeline.
// ----------------------------------------------------------------------------
package qmn_pkg;

	localparam int CW = 16;                            // component width
	localparam int FB = 14;                            // fraction bits
	localparam int PW = 2 * CW + 2;                    // signed product sum width
	localparam int SHIFT = (2 * CW > 30) ? (2 * CW - 30) : 0;
	localparam int MW = PW - 1 - SHIFT;                // reduced magnitude width
	localparam int SW = 2 * MW + 2;                    // sum of squares width
	localparam int SQ_STEPS = SW / 2;                  // root bits, one per stage
	localparam int NW = SQ_STEPS;                      // root width
	localparam int QB = FB + 1;                        // quotient bits
	localparam int RW = MW + FB + 3;                   // divider remainder width
	localparam logic [QB-1:0] ONE = QB'(1) << FB;

	typedef struct packed {
		logic signed [CW-1:0] a_w;
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic signed [CW-1:0] a_z;
		logic signed [CW-1:0] b_w;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic signed [CW-1:0] b_z;
	} operands_t;

	typedef struct packed {
		logic signed [CW-1:0] r_w;
		logic signed [CW-1:0] r_x;
		logic signed [CW-1:0] r_y;
		logic signed [CW-1:0] r_z;
		logic                 zero_norm;
	} result_t;

	typedef logic [MW-1:0] mag_t;

	typedef struct packed {
		mag_t [3:0] mag;
		logic [3:0] neg;
	} side_t;

endpackage

// File: design/qmn_isqrt.sv
// ----------------------------------------------------------------------------
// qmn_isqrt: pipelined integer square root
// One result bit per register stage; the sideband rides along with each value.
// ----------------------------------------------------------------------------
module qmn_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [qmn_pkg::SW-1:0] in_sum,
	input  qmn_pkg::side_t         in_side,
	output logic                   out_vld,
	output logic [qmn_pkg::NW-1:0] out_root,
	output qmn_pkg::side_t         out_side
);
	import qmn_pkg::*;

	logic [SQ_STEPS-1:0]         vld_s;
	logic [SQ_STEPS-1:0][SW-1:0] v_s;
	logic [SQ_STEPS-1:0][SW-1:0] res_s;
	side_t [SQ_STEPS-1:0]        side_s;

	logic [SQ_STEPS-1:0][SW-1:0] v_d;
	logic [SQ_STEPS-1:0][SW-1:0] res_d;

	always_comb begin
		logic [SW-1:0] vin;
		logic [SW-1:0] rin;
		logic [SW-1:0] bt;
		logic [SW-1:0] t;
		for (int k = 0; k < SQ_STEPS; k++) begin
			vin = (k == 0) ? in_sum : v_s[(k == 0) ? 0 : k - 1];
			rin = (k == 0) ? '0 : res_s[(k == 0) ? 0 : k - 1];
			bt = SW'(1) << (SW - 2 - 2 * k);
			t = rin + bt;
			if (vin >= t) begin
				v_d[k] = vin - t;
				res_d[k] = (rin >> 1) + bt;
			end else begin
				v_d[k] = vin;
				res_d[k] = rin >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SQ_STEPS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s <= v_d;
			res_s <= res_d;
			side_s <= {side_s[SQ_STEPS-2:0], in_side};
		end
	end

	assign out_vld = vld_s[SQ_STEPS-1];
	assign out_root = res_s[SQ_STEPS-1][NW-1:0];
	assign out_side = side_s[SQ_STEPS-1];

endmodule

// File: design/quaternion_multiply_normalize.sv
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize: Hamilton product scaled to unit length
// Products, reduction, sum of squares, pipelined root and pipelined divide.
// ----------------------------------------------------------------------------
//  channel    dir  handshake                      payload
//  operands   in   operands_valid/operands_ready  operands_t (a, b in Q1.14)
//  result     out  result_valid/result_ready      result_t (unit product)
//
// One request per cycle while the result is not stalled; the depth is set by
// the one-bit-per-stage root and quotient pipelines.
// Reset clears only the valid bits. A stalled result freezes the whole
// pipeline; requests are taken whenever the output register is free or taken.
module quaternion_multiply_normalize (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                operands_valid,
	output logic                operands_ready,
	input  qmn_pkg::operands_t  operands,
	output logic                result_valid,
	input  logic                result_ready,
	output qmn_pkg::result_t    result
);
	import qmn_pkg::*;

	logic en;
	assign en = !result_valid || result_ready;
	assign operands_ready = en;

	// stage 1: sixteen products
	logic                           vld_s1;
	logic [15:0][2*CW-1:0]          prod_s1;
	logic [15:0][2*CW-1:0]          prod_d;

	always_comb begin
		prod_d[0]  = operands.a_w * operands.b_w;
		prod_d[1]  = operands.a_x * operands.b_x;
		prod_d[2]  = operands.a_y * operands.b_y;
		prod_d[3]  = operands.a_z * operands.b_z;
		prod_d[4]  = operands.a_w * operands.b_x;
		prod_d[5]  = operands.a_x * operands.b_w;
		prod_d[6]  = operands.a_y * operands.b_z;
		prod_d[7]  = operands.a_z * operands.b_y;
		prod_d[8]  = operands.a_w * operands.b_y;
		prod_d[9]  = operands.a_y * operands.b_w;
		prod_d[10] = operands.a_x * operands.b_z;
		prod_d[11] = operands.a_z * operands.b_x;
		prod_d[12] = operands.a_z * operands.b_w;
		prod_d[13] = operands.a_w * operands.b_z;
		prod_d[14] = operands.a_x * operands.b_y;
		prod_d[15] = operands.a_y * operands.b_x;
	end

	// stage 2: Hamilton sums
	logic                  vld_s2;
	logic [3:0][PW-1:0]    p_s2;
	logic [15:0][PW-1:0]   pe;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			pe[i] = PW'($signed(prod_s1[i]));
		end
	end

	// stage 3: sign and reduced magnitude
	logic                  vld_s3;
	side_t                 side_s3;
	side_t                 side_d3;

	always_comb begin
		logic [PW-1:0] absv;
		logic [PW-1:0] sh;
		for (int i = 0; i < 4; i++) begin
			absv = p_s2[i][PW-1] ? (PW'(0) - p_s2[i]) : p_s2[i];
			sh = absv >> SHIFT;
			side_d3.neg[i] = p_s2[i][PW-1];
			side_d3.mag[i] = sh[MW-1:0];
		end
	end

	// stage 4: squares, stage 5: sum
	logic                   vld_s4;
	logic [3:0][2*MW-1:0]   sq_s4;
	side_t                  side_s4;
	logic                   vld_s5;
	logic [SW-1:0]          sum_s5;
	side_t                  side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= operands_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_d;
			p_s2[0] <= pe[0] - pe[1] - pe[2] - pe[3];
			p_s2[1] <= pe[4] + pe[5] + pe[6] - pe[7];
			p_s2[2] <= pe[8] + pe[9] - pe[10] + pe[11];
			p_s2[3] <= pe[12] + pe[13] + pe[14] - pe[15];
			side_s3 <= side_d3;
			for (int i = 0; i < 4; i++) begin
				sq_s4[i] <= side_s3.mag[i] * side_s3.mag[i];
			end
			side_s4 <= side_s3;
			sum_s5 <= (SW'(sq_s4[0]) + SW'(sq_s4[1])) + (SW'(sq_s4[2]) + SW'(sq_s4[3]));
			side_s5 <= side_s4;
		end
	end

	// root
	logic          rt_vld;
	logic [NW-1:0] rt_root;
	side_t         rt_side;

	qmn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_sum   (sum_s5),
		.in_side  (side_s5),
		.out_vld  (rt_vld),
		.out_root (rt_root),
		.out_side (rt_side)
	);

	// divide: q = (mag * 2^(FB+1) + n) / (2n), one quotient bit per stage
	logic [QB-1:0]               dv_vld_s;
	logic [QB-1:0][NW-1:0]       dv_n_s;
	side_t [QB-1:0]              dv_side_s;
	logic [QB-1:0][3:0][RW-1:0]  dv_rem_s;
	logic [QB-1:0][3:0][QB-1:0]  dv_q_s;
	logic [QB-1:0][3:0][RW-1:0]  rem_d;
	logic [QB-1:0][3:0][QB-1:0]  q_d;

	always_comb begin
		logic [RW-1:0] rin;
		logic [QB-1:0] qin;
		logic [NW-1:0] nin;
		logic [RW-1:0] dk;
		for (int k = 0; k < QB; k++) begin
			nin = (k == 0) ? rt_root : dv_n_s[(k == 0) ? 0 : k - 1];
			dk = (RW'(nin) << 1) << (QB - 1 - k);
			for (int i = 0; i < 4; i++) begin
				if (k == 0) begin
					rin = (RW'(rt_side.mag[i]) << (FB + 1)) + RW'(rt_root);
					qin = '0;
				end else begin
					rin = dv_rem_s[(k == 0) ? 0 : k - 1][i];
					qin = dv_q_s[(k == 0) ? 0 : k - 1][i];
				end
				if (rin >= dk) begin
					rem_d[k][i] = rin - dk;
					q_d[k][i] = qin | (QB'(1) << (QB - 1 - k));
				end else begin
					rem_d[k][i] = rin;
					q_d[k][i] = qin;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s <= '0;
		end else if (en) begin
			dv_vld_s <= {dv_vld_s[QB-2:0], rt_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s <= rem_d;
			dv_q_s <= q_d;
			dv_n_s <= {dv_n_s[QB-2:0], rt_root};
			dv_side_s <= {dv_side_s[QB-2:0], rt_side};
		end
	end

	// output register: clamp, sign, zero-norm case
	logic    out_vld_q;
	result_t out_q;
	result_t out_d;

	always_comb begin
		logic [QB-1:0]     qc;
		logic [CW-1:0]     rv [4];
		logic              zn;
		zn = (dv_n_s[QB-1] == '0);
		for (int i = 0; i < 4; i++) begin
			qc = (dv_q_s[QB-1][i] > ONE) ? ONE : dv_q_s[QB-1][i];
			if (zn) begin
				rv[i] = '0;
			end else if (dv_side_s[QB-1].neg[i]) begin
				rv[i] = CW'(0) - CW'(qc);
			end else begin
				rv[i] = CW'(qc);
			end
		end
		out_d.r_w = rv[0];
		out_d.r_x = rv[1];
		out_d.r_y = rv[2];
		out_d.r_z = rv[3];
		out_d.zero_norm = zn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_d;
		end
	end

	assign result_valid = out_vld_q;
	assign result = out_q;

	// zero norm gives an all-zero quaternion
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_norm |->
			result.r_w == 0 && result.r_x == 0 && result.r_y == 0 && result.r_z == 0)
		else $error("zero-norm result carries nonzero components");

	// a nonzero norm always leaves at least one nonzero component
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.zero_norm |->
			result.r_w != 0 || result.r_x != 0 || result.r_y != 0 || result.r_z != 0)
		else $error("nonzero-norm result is all zero");

	// saturation bound, checked on r_w and r_x
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			$signed(result.r_w) <= $signed({1'b0, ONE}) &&
			$signed(result.r_w) >= -$signed({1'b0, ONE}) &&
			$signed(result.r_x) <= $signed({1'b0, ONE}) &&
			$signed(result.r_x) >= -$signed({1'b0, ONE}))
		else $error("result component outside unit range");

endmodule
